>>> hw/rtl/rfht_pkg.sv
// ----------------------------------------------------------------------------
// rfht_pkg
// Types and constants of the TLS record framer and handshake tracker.
// ----------------------------------------------------------------------------
package rfht_pkg;

  localparam logic [2:0] HDR_LEN = 3'd5;

  localparam logic [7:0] CT_CCS       = 8'd20;
  localparam logic [7:0] CT_ALERT     = 8'd21;
  localparam logic [7:0] CT_HANDSHAKE = 8'd22;
  localparam logic [7:0] CT_APPDATA   = 8'd23;

  localparam logic [7:0] HS_CLIENT_HELLO = 8'd1;
  localparam logic [7:0] HS_SERVER_HELLO = 8'd2;

  localparam logic [2:0] ST_INITIAL      = 3'd0;
  localparam logic [2:0] ST_CLIENT_HELLO = 3'd1;
  localparam logic [2:0] ST_SERVER_HELLO = 3'd2;
  localparam logic [2:0] ST_SERVER_CCS   = 3'd3;
  localparam logic [2:0] ST_CLIENT_CCS   = 3'd4;
  localparam logic [2:0] ST_ESTABLISHED  = 3'd5;
  localparam logic [2:0] ST_BLOCKED      = 3'd6;

  localparam logic DIR_SERVER = 1'b0;
  localparam logic DIR_CLIENT = 1'b1;

  localparam logic [1:0] V_NONE      = 2'd0;
  localparam logic [1:0] V_ACCEPT    = 2'd1;
  localparam logic [1:0] V_DECRYPT   = 2'd2;
  localparam logic [1:0] V_MALICIOUS = 2'd3;

  localparam logic [15:0] FIN_LEN_RESET = 16'd65;

  typedef struct packed {
    logic       direction;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic        record_done;
    logic [7:0]  content_type;
    logic [15:0] record_length;
    logic [1:0]  verdict;
    logic [31:0] record_index;
    logic [2:0]  conn_state;
    logic        cipher_valid;
    logic [7:0]  cipher_byte;
    logic [15:0] peak_version;
  } out_t;

endpackage

>>> hw/rtl/rfht_queue.sv
// ----------------------------------------------------------------------------
// rfht_queue
// Front queue: accepts payload bytes and holds them for the record engine.
// ----------------------------------------------------------------------------
module rfht_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rfht_pkg::in_t in_data,
  output logic          q_valid,
  output rfht_pkg::in_t q_data,
  input  logic          q_pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rfht_pkg::in_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push;
  logic          pop;

  assign in_ready = (count_r != CW'(DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_data   = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

>>> hw/rtl/rfht_engine.sv
// ----------------------------------------------------------------------------
// rfht_engine
// Back end: frames records per direction, tracks the handshake, registers
// one result per byte.
// ----------------------------------------------------------------------------
module rfht_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  rfht_pkg::in_t  q_data,
  output logic           q_pop,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [15:0]    cfg_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rfht_pkg::out_t out_data
);

  logic [2:0]  hc_r   [2];
  logic [7:0]  type_r [2];
  logic [15:0] len_r  [2];
  logic [15:0] bl_r   [2];
  logic [7:0]  fbb_r  [2];
  logic        cr_r   [2];
  logic [15:0] max_r  [2];
  logic [31:0] cnt_r  [2];
  logic [15:0] stg_r  [2];
  logic [2:0]  hs_r, hs_nxt;
  logic [15:0] fin_len_r;
  logic        out_valid_r, out_valid_nxt;
  rfht_pkg::out_t out_r;

  logic        take;
  logic        d;
  logic [7:0]  b;
  logic [2:0]  hc;
  logic [7:0]  ty;
  logic [15:0] len;
  logic [15:0] bl;
  logic [7:0]  fbb;
  logic        cr;
  logic [15:0] mv;
  logic [31:0] cnt;
  logic [15:0] stg;
  logic        done;
  logic        cv;
  logic [1:0]  verdict;
  rfht_pkg::out_t res;

  assign take      = q_valid && (!out_valid_r || out_ready);
  assign q_pop     = take;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    d       = q_data.direction;
    b       = q_data.data_byte;
    hc      = hc_r[d];
    ty      = type_r[d];
    len     = len_r[d];
    bl      = bl_r[d];
    fbb     = fbb_r[d];
    cr      = cr_r[d];
    mv      = max_r[d];
    cnt     = cnt_r[d];
    stg     = stg_r[d];
    hs_nxt  = hs_r;
    done    = 1'b0;
    cv      = 1'b0;
    verdict = rfht_pkg::V_NONE;
    if (hs_r != rfht_pkg::ST_BLOCKED) begin
      if (hc < rfht_pkg::HDR_LEN) begin
        unique case (hc)
          3'd0:    ty  = b;
          3'd1:    stg = {b, 8'h00};
          3'd2:    stg = stg | {8'h00, b};
          3'd3:    len = {b, 8'h00};
          default: len = len | {8'h00, b};
        endcase
        hc = hc + 3'd1;
        if (hc == rfht_pkg::HDR_LEN) begin
          bl   = len;
          fbb  = b;
          cr   = (ty == rfht_pkg::CT_APPDATA) && (hs_r == rfht_pkg::ST_ESTABLISHED);
          done = (len == 16'd0);
        end
      end else begin
        if (bl == len) begin
          fbb = b;
        end
        cv = cr && (hs_r == rfht_pkg::ST_ESTABLISHED);
        if (bl != 16'd0) begin
          bl = bl - 16'd1;
        end
        done = (bl == 16'd0);
      end
      if (done) begin
        if (stg > mv) begin
          mv = stg;
        end
        verdict = rfht_pkg::V_MALICIOUS;
        hs_nxt  = rfht_pkg::ST_BLOCKED;
        unique case (ty)
          rfht_pkg::CT_CCS: begin
            priority if (d == rfht_pkg::DIR_SERVER && hs_r == rfht_pkg::ST_SERVER_HELLO) begin
              hs_nxt  = rfht_pkg::ST_SERVER_CCS;
              verdict = rfht_pkg::V_ACCEPT;
            end else if (d == rfht_pkg::DIR_CLIENT && hs_r == rfht_pkg::ST_SERVER_CCS) begin
              hs_nxt  = rfht_pkg::ST_CLIENT_CCS;
              verdict = rfht_pkg::V_ACCEPT;
            end else begin
              hs_nxt  = rfht_pkg::ST_BLOCKED;
            end
          end
          rfht_pkg::CT_ALERT: begin
            hs_nxt  = hs_r;
            verdict = rfht_pkg::V_NONE;
          end
          rfht_pkg::CT_HANDSHAKE: begin
            priority if (fbb == rfht_pkg::HS_CLIENT_HELLO &&
                         hs_r == rfht_pkg::ST_INITIAL) begin
              hs_nxt  = rfht_pkg::ST_CLIENT_HELLO;
              verdict = rfht_pkg::V_ACCEPT;
            end else if (fbb == rfht_pkg::HS_SERVER_HELLO &&
                         hs_r == rfht_pkg::ST_CLIENT_HELLO) begin
              hs_nxt  = rfht_pkg::ST_SERVER_HELLO;
              verdict = rfht_pkg::V_ACCEPT;
            end else begin
              hs_nxt  = rfht_pkg::ST_BLOCKED;
            end
          end
          rfht_pkg::CT_APPDATA: begin
            priority if (hs_r == rfht_pkg::ST_SERVER_CCS && d == rfht_pkg::DIR_SERVER) begin
              hs_nxt  = hs_r;
              verdict = rfht_pkg::V_ACCEPT;
            end else if (hs_r == rfht_pkg::ST_CLIENT_CCS && d == rfht_pkg::DIR_CLIENT &&
                         len == fin_len_r) begin
              hs_nxt  = rfht_pkg::ST_ESTABLISHED;
              verdict = rfht_pkg::V_ACCEPT;
            end else if (hs_r == rfht_pkg::ST_ESTABLISHED) begin
              hs_nxt  = hs_r;
              verdict = rfht_pkg::V_DECRYPT;
            end else begin
              hs_nxt  = rfht_pkg::ST_BLOCKED;
            end
          end
          default: begin
            hs_nxt = rfht_pkg::ST_BLOCKED;
          end
        endcase
        if (verdict == rfht_pkg::V_DECRYPT && cnt != '1) begin
          cnt = cnt + 32'd1;
        end
        hc = 3'd0;
      end
    end
    res.record_done   = done;
    res.content_type  = ty;
    res.record_length = len;
    res.verdict       = verdict;
    res.record_index  = cnt_r[d];
    res.conn_state    = hs_nxt;
    res.cipher_valid  = cv;
    res.cipher_byte   = b;
    res.peak_version  = mv;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        hc_r[i]   <= '0;
        type_r[i] <= '0;
        len_r[i]  <= '0;
        bl_r[i]   <= '0;
        fbb_r[i]  <= '0;
        cr_r[i]   <= 1'b0;
        max_r[i]  <= '0;
        cnt_r[i]  <= '0;
        stg_r[i]  <= '0;
      end
      hs_r        <= rfht_pkg::ST_INITIAL;
      fin_len_r   <= rfht_pkg::FIN_LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        hc_r[d]   <= hc;
        type_r[d] <= ty;
        len_r[d]  <= len;
        bl_r[d]   <= bl;
        fbb_r[d]  <= fbb;
        cr_r[d]   <= cr;
        max_r[d]  <= mv;
        cnt_r[d]  <= cnt;
        stg_r[d]  <= stg;
        hs_r      <= hs_nxt;
      end
      if (cfg_valid) begin
        fin_len_r <= cfg_data;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= res;
    end
  end

  a_blocked_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (hs_r == rfht_pkg::ST_BLOCKED) |=> (hs_r == rfht_pkg::ST_BLOCKED))
    else $error("blocked connection left blocked state");

  a_verdict_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.verdict != rfht_pkg::V_NONE) |-> out_r.record_done)
    else $error("verdict without record end");

  a_cipher_established: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.cipher_valid) |-> (out_r.conn_state == rfht_pkg::ST_ESTABLISHED))
    else $error("ciphertext flagged outside established state");

endmodule

>>> hw/rtl/tls_record_framer_handshake_tracker_core.sv
// ----------------------------------------------------------------------------
// tls_record_framer_handshake_tracker_core
// TLS record framer and handshake tracker: frames records per direction,
// follows the handshake and flags application ciphertext.
//
//   channel  ports                          transfer
//   in       in_valid/in_ready/in_data      one payload byte with direction
//   out      out_valid/out_ready/out_data   one result per byte
//   cfg      cfg_valid/cfg_ready/cfg_data   Finished record length
//
// One byte per cycle sustained while out_ready is high; per-direction framing
// state and the shared handshake state update in the engine once per byte.
// out_valid rises once the byte has passed a queue slot and then the
// output register; out_ready low holds the result in that register.
// Reset is synchronous; it clears all framing, handshake and count state.
// The queue holds QUEUE_DEPTH bytes while out stalls; cfg_ready is always high.
// ----------------------------------------------------------------------------
module tls_record_framer_handshake_tracker_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rfht_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rfht_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [15:0]    cfg_data
);

  logic          q_valid;
  rfht_pkg::in_t q_data;
  logic          q_pop;

  rfht_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  rfht_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
